[sv/triangle_quality_min_stream_defines.svh]
// ----------------------------------------------------------------------------
// Triangle quality stream assertion macros
// Shared property forms for the checker of the triangle quality stream.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_QUALITY_MIN_STREAM_DEFINES_SVH
`define TRIANGLE_QUALITY_MIN_STREAM_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TQM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle quality stream check failed");

// Next-cycle implication, off during reset.
`define TQM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangle quality stream check failed");

// Implication that is also checked during reset.
`define TQM_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("triangle quality stream check failed");

`endif

[sv/tqm_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle quality package
// Shared constants, types and helpers for the triangle quality stream.
// ----------------------------------------------------------------------------
package tqm_pkg;

  localparam int CoordBitsDef  = 12;
  localparam int FracBitsDef   = 16;
  localparam int FieldW        = 12;
  localparam int NumCoords     = 9;
  localparam int InDataW       = 112;
  localparam int MetricW       = 52;
  localparam int OutDataW      = 2 * MetricW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_OUT
  } tqm_state_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } tqm_div_stat_t;

endpackage

[sv/tqm_mul.sv]
// ----------------------------------------------------------------------------
// Triangle quality multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tqm_mul
  import tqm_pkg::*;
#(
  parameter int OpW = 27
) (
  input  logic                   clk,
  input  logic signed [OpW-1:0]  op_a,
  input  logic signed [OpW-1:0]  op_b,
  output logic signed [2*OpW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

[sv/tqm_div.sv]
// ----------------------------------------------------------------------------
// Triangle quality divider
// Restoring fraction divider, one quotient bit per cycle, for num < den.
// ----------------------------------------------------------------------------
module tqm_div
  import tqm_pkg::*;
#(
  parameter int NumW     = 52,
  parameter int FracBits = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NumW-1:0]     num,
  input  logic [NumW-1:0]     den,
  output tqm_div_stat_t       stat,
  output logic [FracBits-1:0] quot
);

  localparam int CntW = $clog2(FracBits + 1);

  logic            busy;
  logic            done;
  logic [CntW-1:0] cnt;
  logic [NumW:0]   rem;
  logic [NumW-1:0] den_r;
  logic [NumW:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem[NumW-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(FracBits - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_r <= den;
      quot  <= '0;
    end else if (busy) begin
      rem  <= fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quot <= {quot[FracBits-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[sv/triangle_quality_min_stream.sv]
// ----------------------------------------------------------------------------
// Triangle quality minimum stream
// Per-triangle quality or squared doubled area, with a running list minimum.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: ax ay az bx by bz cx cy cz (12 bits each), tlast: list_end
// m_axis    out  tdata: metric worst_so_far (52 bits each), tlast: last
// cfg       in   cfg_wr_en, cfg_wr_data: metric_mode
//
// A result is offered once its item has run the multiply steps and, in quality
// mode for a triangle that is not degenerate, the division; the next item can
// be taken in the cycle after the result leaves.
// The 19 products run one a cycle through the one shared multiplier, and the
// quality division takes one quotient bit a cycle in the shared divider.
// Reset is synchronous and active high; it clears the mode, the running
// minimum and the handshake state. A result waits in the output register
// while m_axis_tready is low, and no new item is taken until it has gone.
//
module triangle_quality_min_stream
  import tqm_pkg::*;
#(
  parameter int COORD_BITS        = CoordBitsDef,
  parameter int QUALITY_FRAC_BITS = FracBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  // ax ay az bx by bz cx cy cz, 12 bits each, zero padding on top
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // metric, then worst_so_far, 52 bits each
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  // Differences carry one bit more than a coordinate.
  localparam int DiffW = COORD_BITS + 1;
  // Cross components and squared lengths both fit in twice that.
  localparam int HalfW = 2 * DiffW;
  // The multiplier takes an unsigned squared length as a signed operand.
  localparam int OpW   = HalfW + 1;
  localparam int ProdW = 2 * OpW;
  // Squared cross product and squared longest edge.
  localparam int CrossW = 2 * HalfW;
  localparam int StepW  = 5;
  localparam logic [StepW-1:0] StepLast = StepW'(19);

  tqm_state_t state, state_next;

  logic                     metric_mode;
  logic [MetricW-1:0]       running_min;
  logic                     list_start;
  logic                     item_end;
  logic [StepW-1:0]         step;

  logic signed [DiffW-1:0]  e [3];
  logic signed [DiffW-1:0]  f [3];
  logic signed [DiffW-1:0]  g [3];
  logic signed [HalfW-1:0]  n [3];
  logic [HalfW-1:0]         len [3];
  logic [HalfW-1:0]         lmax;
  logic signed [ProdW-1:0]  acc;
  logic [CrossW-1:0]        cross2;
  logic [CrossW-1:0]        lmax_sq;

  logic signed [OpW-1:0]    op_a;
  logic signed [OpW-1:0]    op_b;
  logic signed [ProdW-1:0]  prod;

  logic signed [DiffW-1:0]  pa [3];
  logic signed [DiffW-1:0]  pb [3];
  logic signed [DiffW-1:0]  pc [3];

  logic                     accept;
  logic                     div_start;
  tqm_div_stat_t            div_stat;
  logic [QUALITY_FRAC_BITS-1:0] quot;

  logic                     fin;
  logic [MetricW-1:0]       fin_metric;
  logic [MetricW-1:0]       new_min;
  logic [HalfW-1:0]         max_ab;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // Each coordinate is the low COORD_BITS of its field, sign extended.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = DiffW'($signed(s_axis_tdata[FieldW*i +: COORD_BITS]));
      pb[i] = DiffW'($signed(s_axis_tdata[FieldW*(i+3) +: COORD_BITS]));
      pc[i] = DiffW'($signed(s_axis_tdata[FieldW*(i+6) +: COORD_BITS]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      metric_mode <= cfg_wr_data;
    end
  end

  // Edge vectors: e = b - a, f = c - a, g = c - b.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        e[i] <= pb[i] - pa[i];
        f[i] <= pc[i] - pa[i];
        g[i] <= pc[i] - pb[i];
      end
      item_end <= s_axis_tlast;
    end
  end

  // Operand schedule for the shared multiplier, one product a step.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      5'd0:  begin op_a = OpW'(e[1]); op_b = OpW'(f[2]); end
      5'd1:  begin op_a = OpW'(e[2]); op_b = OpW'(f[1]); end
      5'd2:  begin op_a = OpW'(e[2]); op_b = OpW'(f[0]); end
      5'd3:  begin op_a = OpW'(e[0]); op_b = OpW'(f[2]); end
      5'd4:  begin op_a = OpW'(e[0]); op_b = OpW'(f[1]); end
      5'd5:  begin op_a = OpW'(e[1]); op_b = OpW'(f[0]); end
      5'd6:  begin op_a = OpW'(e[0]); op_b = OpW'(e[0]); end
      5'd7:  begin op_a = OpW'(e[1]); op_b = OpW'(e[1]); end
      5'd8:  begin op_a = OpW'(e[2]); op_b = OpW'(e[2]); end
      5'd9:  begin op_a = OpW'(g[0]); op_b = OpW'(g[0]); end
      5'd10: begin op_a = OpW'(g[1]); op_b = OpW'(g[1]); end
      5'd11: begin op_a = OpW'(g[2]); op_b = OpW'(g[2]); end
      5'd12: begin op_a = OpW'(f[0]); op_b = OpW'(f[0]); end
      5'd13: begin op_a = OpW'(f[1]); op_b = OpW'(f[1]); end
      5'd14: begin op_a = OpW'(f[2]); op_b = OpW'(f[2]); end
      5'd15: begin op_a = OpW'(n[0]); op_b = OpW'(n[0]); end
      5'd16: begin op_a = OpW'(n[1]); op_b = OpW'(n[1]); end
      5'd17: begin op_a = OpW'(n[2]); op_b = OpW'(n[2]); end
      5'd18: begin op_a = OpW'({1'b0, lmax}); op_b = OpW'({1'b0, lmax}); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  tqm_mul #(
    .OpW (OpW)
  ) u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign max_ab = (len[1] > len[0]) ? len[1] : len[0];

  // Each step folds in the registered product issued at the step before.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      unique case (step)
        5'd1, 5'd3, 5'd5, 5'd7, 5'd10, 5'd13: acc <= prod;
        5'd2:  n[0] <= HalfW'(acc - prod);
        5'd4:  n[1] <= HalfW'(acc - prod);
        5'd6:  n[2] <= HalfW'(acc - prod);
        5'd8, 5'd11, 5'd14, 5'd17: acc <= acc + prod;
        5'd9:  len[0] <= HalfW'(acc + prod);
        5'd12: len[1] <= HalfW'(acc + prod);
        5'd15: len[2] <= HalfW'(acc + prod);
        5'd16: begin
          acc  <= prod;
          lmax <= (len[2] > max_ab) ? len[2] : max_ab;
        end
        5'd18: cross2  <= CrossW'(acc + prod);
        5'd19: lmax_sq <= CrossW'(prod);
        default: acc <= acc;
      endcase
    end
  end

  // The quality is below one, so the divider only forms fraction bits.
  tqm_div #(
    .NumW     (CrossW),
    .FracBits (QUALITY_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (cross2),
    .den   (lmax_sq),
    .stat  (div_stat),
    .quot  (quot)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    fin        = 1'b0;
    fin_metric = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (step == StepLast) state_next = ST_CHK;
      end
      ST_CHK: begin
        if (metric_mode) begin
          fin        = 1'b1;
          fin_metric = MetricW'(cross2);
          state_next = ST_OUT;
        end else if (cross2 == '0 || lmax_sq == '0) begin
          // Degenerate triangle: no division, metric zero.
          fin        = 1'b1;
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          fin        = 1'b1;
          fin_metric = MetricW'(quot);
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign new_min = (list_start || fin_metric < running_min) ? fin_metric : running_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      running_min <= '0;
      list_start  <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_MUL) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
      if (fin) begin
        running_min <= item_end ? '0 : new_min;
        list_start  <= item_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      m_axis_tdata <= {new_min, fin_metric};
      m_axis_tlast <= item_end;
    end
  end

  assign m_axis_tvalid = (state == ST_OUT);

endmodule

[sv/tqm_checker.sv]
// ----------------------------------------------------------------------------
// Triangle quality checker
// Port-level checks on the triangle quality stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_quality_min_stream_defines.svh"

module tqm_checker
  import tqm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                s_axis_tlast,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic                cfg_wr_en,
  input logic                cfg_wr_data
);

  // A waiting result holds its payload.
  `TQM_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Only one item is in the block at a time.
  `TQM_ASSERT_SAME(a_one_item, clk, rst, m_axis_tvalid, !s_axis_tready)

  // An accepted item keeps the input closed on the next cycle.
  `TQM_ASSERT_NEXT(a_busy_after, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid)

  // Reset leaves no result pending when it is released.
  `TQM_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) && !rst, !m_axis_tvalid && s_axis_tready)

endmodule

bind triangle_quality_min_stream tqm_checker u_tqm_checker (.*);

[test/triangle_quality_min_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle quality stream checker
// Watches both stream channels and the mode port, predicts each triangle's
// metric and running list minimum, and compares every result field by field.
// ----------------------------------------------------------------------------
module triangle_quality_min_stream_checker
  import tqm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  result_count
);

  typedef struct packed {
    logic [MetricW-1:0] metric;
    logic [MetricW-1:0] worst;
    logic               last;
  } tri_result_t;

  tri_result_t      expected_results[$];
  logic             area_mode;
  logic [MetricW-1:0] list_min;
  logic             list_open;

  function automatic longint coord_at(logic [InDataW-1:0] d, int idx);
    logic signed [FieldW-1:0] v;
    v = d[idx*FieldW +: FieldW];
    return longint'(v);
  endfunction

  // Restoring division for floor(num * 2^16 / den), with num <= den.
  function automatic logic [MetricW-1:0] quality_div(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    logic [127:0] r;
    q = num / den;
    r = num % den;
    for (int k = 0; k < FracBitsDef; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q[MetricW-1:0];
  endfunction

  function automatic logic [MetricW-1:0] triangle_metric(logic [InDataW-1:0] d, logic mode);
    longint e0, e1, e2, f0, f1, f2, g0, g1, g2, n0, n1, n2;
    logic [127:0] cr, lab, lbc, lca, lmax;
    e0 = coord_at(d, 3) - coord_at(d, 0);
    e1 = coord_at(d, 4) - coord_at(d, 1);
    e2 = coord_at(d, 5) - coord_at(d, 2);
    f0 = coord_at(d, 6) - coord_at(d, 0);
    f1 = coord_at(d, 7) - coord_at(d, 1);
    f2 = coord_at(d, 8) - coord_at(d, 2);
    g0 = coord_at(d, 6) - coord_at(d, 3);
    g1 = coord_at(d, 7) - coord_at(d, 4);
    g2 = coord_at(d, 8) - coord_at(d, 5);
    n0 = e1 * f2 - e2 * f1;
    n1 = e2 * f0 - e0 * f2;
    n2 = e0 * f1 - e1 * f0;
    cr  = 128'(n0 * n0) + 128'(n1 * n1) + 128'(n2 * n2);
    lab = 128'(e0 * e0 + e1 * e1 + e2 * e2);
    lbc = 128'(g0 * g0 + g1 * g1 + g2 * g2);
    lca = 128'(f0 * f0 + f1 * f1 + f2 * f2);
    lmax = lab;
    if (lbc > lmax) lmax = lbc;
    if (lca > lmax) lmax = lca;
    if (mode) return cr[MetricW-1:0];
    if (lmax == 0 || cr == 0) return '0;
    return quality_div(cr, lmax * lmax);
  endfunction

  assign pending_count = expected_results.size();

  always_ff @(posedge clk) begin
    tri_result_t exp_r;
    logic [MetricW-1:0] m;
    int errs;
    if (rst) begin
      area_mode    <= 1'b0;
      list_min     <= '0;
      list_open    <= 1'b1;
      fail_count   <= 0;
      result_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) area_mode <= cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        m = triangle_metric(s_axis_tdata, area_mode);
        exp_r.metric = m;
        exp_r.worst  = (list_open || m < list_min) ? m : list_min;
        exp_r.last   = s_axis_tlast;
        expected_results = {expected_results, exp_r};
        list_min  <= s_axis_tlast ? '0 : exp_r.worst;
        list_open <= s_axis_tlast;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          errs = 0;
          if (m_axis_tdata[MetricW-1:0] !== exp_r.metric) begin
            $error("metric: expected %0d, got %0d", exp_r.metric,
                   m_axis_tdata[MetricW-1:0]);
            errs++;
          end
          if (m_axis_tdata[OutDataW-1:MetricW] !== exp_r.worst) begin
            $error("worst_so_far: expected %0d, got %0d", exp_r.worst,
                   m_axis_tdata[OutDataW-1:MetricW]);
            errs++;
          end
          if (m_axis_tlast !== exp_r.last) begin
            $error("last: expected %0b, got %0b", exp_r.last, m_axis_tlast);
            errs++;
          end
          fail_count <= fail_count + errs;
        end
      end
    end
  end

endmodule

[test/triangle_quality_min_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle quality stream testbench
// Drives directed and random triangle lists in both metric modes, with random
// gaps on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module triangle_quality_min_stream_tb;
  import tqm_pkg::*;

  logic                clk;
  logic                rst;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_wr_en;
  logic                cfg_wr_data;
  int                  fail_count;
  int                  pending_count;
  int                  result_count;
  // When set, neither side idles.
  logic                steady;
  int                  triangle_count;

  triangle_quality_min_stream i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  triangle_quality_min_stream_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run ends here if the block stops making progress.
  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  // The receiver stalls in random bursts unless steady.
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(3) == 0) begin
        hold = $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Sends one triangle and holds it until the block takes it. A random gap
  // may come first. Valid stays high afterwards until the next gap or the
  // next mode change, so items can follow without a bubble.
  task automatic send_triangle(input logic [NumCoords*FieldW-1:0] coords, input logic end_flag);
    int gap;
    if (!steady && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {{(InDataW - NumCoords*FieldW){1'b0}}, coords};
    s_axis_tlast  <= end_flag;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    triangle_count++;
  endtask

  // Writes the mode once every result is back and the block has settled.
  task automatic set_mode(input logic mode);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [NumCoords*FieldW-1:0] pack9(int p[9]);
    logic [NumCoords*FieldW-1:0] v;
    for (int i = 0; i < NumCoords; i++) v[i*FieldW +: FieldW] = FieldW'(p[i]);
    return v;
  endfunction

  // Random coordinate: mostly small, sometimes full range or an extreme.
  function automatic logic [FieldW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 12'h800 : 12'h7ff;
      1, 2: return FieldW'($urandom);
      default: return FieldW'(int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [NumCoords*FieldW-1:0] c;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < NumCoords; k++) c[k*FieldW +: FieldW] = rand_coord();
      // Sometimes collapse a corner or an edge to reach degenerate cases.
      if ($urandom_range(15) == 0) c[3*FieldW +: 3*FieldW] = c[0 +: 3*FieldW];
      if ($urandom_range(31) == 0) c[6*FieldW +: 3*FieldW] = c[0 +: 3*FieldW];
      send_triangle(c, $urandom_range(5) == 0);
    end
    send_triangle(c, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    steady = 1'b0;
    triangle_count = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part in both modes: equilateral-ish, right, extremes,
    // degenerate (coincident, collinear, all points equal), list boundaries.
    for (int mode = 0; mode < 2; mode++) begin
      set_mode(mode[0]);
      send_triangle(pack9('{0, 0, 0, 10, 0, 0, 5, 9, 0}), 1'b0);
      send_triangle(pack9('{0, 0, 0, 3, 0, 0, 0, 4, 0}), 1'b0);
      send_triangle(pack9('{-2048, -2048, -2048, 2047, -2048, 2047, -2048, 2047, 2047}),
                    1'b0);
      send_triangle(pack9('{2047, 2047, 2047, -2048, -2048, -2048, 2047, -2048, 0}), 1'b1);
      send_triangle(pack9('{5, 5, 5, 5, 5, 5, 9, 1, 3}), 1'b0);
      send_triangle(pack9('{0, 0, 0, 1, 1, 1, 2, 2, 2}), 1'b0);
      send_triangle(pack9('{7, -7, 7, 7, -7, 7, 7, -7, 7}), 1'b1);
      send_triangle(pack9('{0, 0, 0, 1, 0, 0, 0, 1, 0}), 1'b1);
      send_triangle(pack9('{-1, -1, -1, 2047, 0, 0, 0, 1, -2048}), 1'b0);
      send_triangle(pack9('{0, 0, 0, 2047, 2047, 2047, 1, 0, 0}), 1'b1);
    end

    // Random phases across mode changes.
    set_mode(1'b0);
    random_phase(600);
    set_mode(1'b1);
    random_phase(600);
    set_mode(1'b0);
    random_phase(400);
    // Final stretch with no idling.
    steady = 1'b1;
    set_mode(1'b1);
    random_phase(150);
    set_mode(1'b0);
    random_phase(150);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d triangles in both metric modes; %0d results checked.",
             triangle_count, result_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
